### rtl/dvpjc_pkg.sv
// Shared types and constants for the camera-port JPEG frame capture block.
package dvpjc_pkg;

    localparam int unsigned CFG_W     = 16;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_CAPTURE_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_JPEG_SPAN = 1'b1;

    localparam logic [7:0] MARK_FF  = 8'hFF;
    localparam logic [7:0] MARK_SOI = 8'hD8;
    localparam logic [7:0] MARK_EOI = 8'hD9;

    localparam int unsigned SPAN_RESET_INT = 320 * 240 / 10 / 2;
    localparam logic [CFG_W-1:0] LIMIT_RESET = 16'hFFFF;
    localparam logic [CFG_W-1:0] SPAN_RESET  = CFG_W'(SPAN_RESET_INT);
    localparam logic [CFG_W-1:0] OFFSET_MAX  = 16'hFFFF;

    // Queue depth between classifier and output stage; at least 2.
    localparam int unsigned P_FIFO_DEPTH = 4;

    typedef struct packed {
        logic       vsync;
        logic       href;
        logic       pclk;
        logic [7:0] pixel_data;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       abort;
    } t_out_item;

    // Up to two result items produced by one input item.
    typedef struct packed {
        logic [1:0] num;
        t_out_item  item0;
        t_out_item  item1;
    } t_push;

endpackage

### rtl/dvpjc_front.sv
// Front end: pin sampling state, marker hunt and result classification.
module dvpjc_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  dvpjc_pkg::t_in_item                 i_item,
    output logic                                o_ready,
    input  logic                                i_room,
    input  logic                                i_cfg_wr_en,
    input  logic [dvpjc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [dvpjc_pkg::CFG_W-1:0]         i_cfg_data,
    output dvpjc_pkg::t_push                    o_push
);
    import dvpjc_pkg::*;

    logic             r_prev_vsync, n_prev_vsync;
    logic             r_prev_pclk, n_prev_pclk;
    logic [7:0]       r_prev_byte, n_prev_byte;
    logic             r_prev_valid, n_prev_valid;
    logic [CFG_W-1:0] r_frame_bytes, n_frame_bytes;
    logic             r_in_jpeg, n_in_jpeg;
    logic [CFG_W-1:0] r_jpeg_offset, n_jpeg_offset;
    logic [CFG_W-1:0] r_capture_limit;
    logic [CFG_W-1:0] r_min_span;

    logic             accept;
    logic             vs_rise, vs_fall;
    logic             in_jpeg_e, prev_valid_e;
    logic [CFG_W-1:0] offset_e, frame_bytes_e, offset_inc;
    logic             capture, after_ff, soi, eoi;

    assign accept  = i_valid & i_room;
    assign o_ready = i_room;

    always_comb begin
        vs_rise       = i_item.vsync & ~r_prev_vsync;
        vs_fall       = ~i_item.vsync & r_prev_vsync;
        // frame edges clear the hunt before this sample's byte is looked at
        in_jpeg_e     = r_in_jpeg & ~vs_rise & ~vs_fall;
        offset_e      = (vs_rise | vs_fall) ? '0 : r_jpeg_offset;
        prev_valid_e  = r_prev_valid & ~vs_rise;
        frame_bytes_e = vs_rise ? '0 : r_frame_bytes;
        capture       = i_item.vsync & i_item.href & i_item.pclk & ~r_prev_pclk
                        & (frame_bytes_e < r_capture_limit);
        after_ff      = prev_valid_e & (r_prev_byte == MARK_FF);
        offset_inc    = (offset_e == OFFSET_MAX) ? offset_e : offset_e + 1'b1;
        soi           = capture & ~in_jpeg_e & after_ff & (i_item.pixel_data == MARK_SOI);
        eoi           = capture & in_jpeg_e & after_ff & (i_item.pixel_data == MARK_EOI)
                        & (offset_inc >= r_min_span);

        n_prev_vsync  = i_item.vsync;
        n_prev_pclk   = i_item.pclk;
        n_prev_byte   = r_prev_byte;
        n_prev_valid  = prev_valid_e;
        n_frame_bytes = frame_bytes_e;
        n_in_jpeg     = in_jpeg_e;
        n_jpeg_offset = offset_e;
        o_push        = '0;

        if (vs_fall && r_in_jpeg) begin
            o_push.num   = 2'd1;
            o_push.item0 = '{out_byte: 8'h00, last: 1'b0, abort: 1'b1};
        end

        if (capture) begin
            if (!in_jpeg_e) begin
                if (soi) begin
                    o_push.num    = 2'd2;
                    o_push.item0  = '{out_byte: MARK_FF, last: 1'b0, abort: 1'b0};
                    o_push.item1  = '{out_byte: MARK_SOI, last: 1'b0, abort: 1'b0};
                    n_in_jpeg     = 1'b1;
                    n_jpeg_offset = '0;
                end
            end else begin
                o_push.num    = 2'd1;
                o_push.item0  = '{out_byte: i_item.pixel_data, last: eoi, abort: 1'b0};
                n_in_jpeg     = ~eoi;
                n_jpeg_offset = eoi ? '0 : offset_inc;
            end
            n_prev_byte   = i_item.pixel_data;
            n_prev_valid  = 1'b1;
            n_frame_bytes = frame_bytes_e + 1'b1;
        end

        if (!accept) begin
            o_push.num = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_vsync  <= 1'b0;
            r_prev_pclk   <= 1'b0;
            r_prev_valid  <= 1'b0;
            r_frame_bytes <= '0;
            r_in_jpeg     <= 1'b0;
            r_jpeg_offset <= '0;
        end else if (accept) begin
            r_prev_vsync  <= n_prev_vsync;
            r_prev_pclk   <= n_prev_pclk;
            r_prev_valid  <= n_prev_valid;
            r_frame_bytes <= n_frame_bytes;
            r_in_jpeg     <= n_in_jpeg;
            r_jpeg_offset <= n_jpeg_offset;
        end
    end

    // previous byte is only read behind its valid flag
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prev_byte <= n_prev_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capture_limit <= LIMIT_RESET;
            r_min_span      <= SPAN_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_CAPTURE_LIMIT: r_capture_limit <= i_cfg_data;
                REG_MIN_JPEG_SPAN: r_min_span      <= i_cfg_data;
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_soi_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.num == 2'd2) |=> r_in_jpeg)
        else $error("start marker did not open a JPEG");

    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((o_push.num != 2'd0) && (o_push.item0.last || o_push.item0.abort)) |=> !r_in_jpeg)
        else $error("JPEG still open after last or abort item");
`endif

endmodule

### rtl/dvpjc_queue.sv
// Small result queue: up to two pushes and one pop per cycle.
module dvpjc_queue #(
    parameter int unsigned DEPTH = dvpjc_pkg::P_FIFO_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dvpjc_pkg::t_push     i_push,
    output logic                 o_room,
    output logic                 o_valid,
    output dvpjc_pkg::t_out_item o_item,
    input  logic                 i_pop
);
    import dvpjc_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_ROOM = CNT_W'(DEPTH - 2);

    t_out_item        r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic [PTR_W-1:0] wr_ptr1, wr_ptr2;
    logic             pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    assign o_room  = (r_count <= CNT_ROOM);
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign pop     = i_pop & o_valid;

    always_comb begin
        wr_ptr1  = ptr_inc(r_wr_ptr);
        wr_ptr2  = ptr_inc(wr_ptr1);
        n_rd_ptr = pop ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        case (i_push.num)
            2'd1:    n_wr_ptr = wr_ptr1;
            2'd2:    n_wr_ptr = wr_ptr2;
            default: n_wr_ptr = r_wr_ptr;
        endcase
        n_count = r_count + CNT_W'(i_push.num) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.item0;
        end
        if (i_push.num == 2'd2) begin
            r_mem[wr_ptr1] <= i_push.item1;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("result queue overflow");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.num != 2'd0) |-> o_room)
        else $error("push without two free entries");
`endif

endmodule

### rtl/dvpjc_back.sv
// Back end: output register that drives the result channel.
module dvpjc_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  dvpjc_pkg::t_out_item i_q_item,
    output logic                 o_q_pop,
    output logic                 o_valid,
    output dvpjc_pkg::t_out_item o_item,
    input  logic                 i_ready
);
    import dvpjc_pkg::*;

    logic      r_valid;
    t_out_item r_item;
    logic      take;

    assign take    = i_q_valid & (~r_valid | i_ready);
    assign o_q_pop = take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= take | (r_valid & ~i_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= i_q_item;
        end
    end

`ifndef SYNTHESIS
    a_item_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_item.abort) |-> (!r_item.last && (r_item.out_byte == 8'h00)))
        else $error("abort item carries data or last");
`endif

endmodule

### rtl/dvp_jpeg_frame_capture.sv
// Top level of the camera-port JPEG frame capture block.
//
// Each input item is one sample of the camera pins (vsync, href, pclk,
// pixel_data) taken on the system clock. A byte is captured on every pclk
// rising edge while vsync and href are high, up to capture_limit bytes per
// frame. The block hunts for FF D8, then emits FF, D8 and every following
// byte; the first FF D9 whose D9 lies at least min_jpeg_span bytes past the
// D8 is emitted with last set and hunting resumes. If vsync falls while a
// JPEG is open, one abort item (byte 0, abort 1) is emitted. A rising edge
// of vsync starts a fresh frame. Rate: one pin sample is taken per cycle
// whenever the result queue has two free entries; a start marker yields two
// result items, everything else at most one; the output register drains one
// result per cycle while i_ready is high, so the queue depth (FIFO_DEPTH)
// sets how long downstream stalls are absorbed before o_ready drops.
// Results pass the queue, then the output register. Registers: index 0
// capture_limit (reset 65535), index 1 min_jpeg_span (reset 3840); the user
// writes both with i_cfg_wr_en only while the block is idle (not enforced).
module dvp_jpeg_frame_capture #(
    parameter int unsigned FIFO_DEPTH = dvpjc_pkg::P_FIFO_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  dvpjc_pkg::t_in_item             i_item,
    output logic                            o_valid,
    input  logic                            i_ready,
    output dvpjc_pkg::t_out_item            o_item,
    input  logic                            i_cfg_wr_en,
    input  logic [dvpjc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dvpjc_pkg::CFG_W-1:0]     i_cfg_data
);
    import dvpjc_pkg::*;

    t_push     push;
    logic      room;
    logic      q_valid;
    t_out_item q_item;
    logic      q_pop;

    // Classify each pin sample and hand 0, 1 or 2 result items to the queue.
    dvpjc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_item      (i_item),
        .o_ready     (o_ready),
        .i_room      (room),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_push      (push)
    );

    // Hold results so that front and output side stall independently.
    dvpjc_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (q_pop)
    );

    // Present one result item per cycle on the output channel while i_ready is high.
    dvpjc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_valid   (o_valid),
        .o_item    (o_item),
        .i_ready   (i_ready)
    );

endmodule
